FILE: rtl/srt_pkg.sv
// Shared types and codes of the sorted record table.
package srt_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_STORED    = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_FOUND     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  // One stored record, as held in a single word of the table memory.
  typedef struct packed {
    logic [63:0] name_key;
    logic [63:0] address_key;
    logic [30:0] phone;
  } record_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_INS_DONE,
    ST_LK_RD,
    ST_LK_CMP,
    ST_LK_END
  } state_t;

endpackage

FILE: rtl/srt_if.sv
// Request and response channel interfaces of the sorted record table.
interface srt_req_if;
  import srt_pkg::*;
  logic        valid;
  logic        ready;
  opcode_t     opcode;
  logic [63:0] name_key;
  logic [63:0] address_key;
  logic [30:0] phone;

  modport source (output valid, opcode, name_key, address_key, phone, input ready);
  modport sink   (input valid, opcode, name_key, address_key, phone, output ready);
endinterface

interface srt_rsp_if;
  import srt_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [63:0] found_name;
  logic [63:0] found_address;
  logic [30:0] found_phone;
  logic        last;

  modport source (output valid, status, found_name, found_address, found_phone, last,
                  input ready);
  modport sink   (input valid, status, found_name, found_address, found_phone, last,
                  output ready);
endinterface

FILE: rtl/sorted_record_table_unit.sv
// Top level of the sorted record table: control sequencer around the record memory.
//
//   channel  dir  transfer carries
//   -------  ---  ---------------------------------------------------------
//   req      in   opcode, name_key, address_key, phone
//   rsp      out  status, found_name, found_address, found_phone, last
//
// An insert walks the memory read port down from the top entry; each entry that
// moves is written one place up in the cycle its read data returns.
// A lookup makes one read and one compare per stored entry; a full rsp register
// stalls the scan. A full table answers an insert without a memory access. Reset
// (rst, synchronous) clears the entry count and the control state only; the memory
// itself is never cleared.
// A new request is taken in the cycle after the last response is loaded, even
// while that response still waits in the output register.
module sorted_record_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst,
  srt_req_if.sink   req,
  srt_rsp_if.source rsp
);
  import srt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t  state, state_next;

  // Entry count and the two scan pointers: j walks down during an insert and is
  // the slot that receives the next write, i walks up during a lookup.
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] j, j_next;
  logic [CW-1:0] i, i_next;

  // The request being worked on.
  logic    req_take;
  record_t new_rec;

  // Insert result code, held until the response register is free.
  status_t res_status, res_status_next;

  // A lookup keeps its latest match back until it knows whether another one
  // follows, so that the last flag can be set on the final response.
  logic    pend_valid, pend_valid_next;
  record_t pend_rec, pend_rec_next;

  // Record memory.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  record_t       ram_wdata, ram_rdata;

  // Response register.
  logic    rsp_valid;
  logic    slot_free;
  logic    out_load;
  status_t out_status;
  record_t out_rec;
  logic    out_last;

  srt_ram #(
    .WIDTH ($bits(record_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign slot_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Payload and pointer registers need no reset: every path sets them before use.
  always_ff @(posedge clk) begin
    j          <= j_next;
    i          <= i_next;
    res_status <= res_status_next;
    pend_rec   <= pend_rec_next;
    if (req_take) begin
      new_rec.name_key    <= req.name_key;
      new_rec.address_key <= req.address_key;
      new_rec.phone       <= req.phone;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    j_next          = j;
    i_next          = i;
    res_status_next = res_status;
    pend_valid_next = pend_valid;
    pend_rec_next   = pend_rec;
    ram_we          = 1'b0;
    ram_waddr       = j;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    out_load        = 1'b0;
    out_status      = STATUS_NOT_FOUND;
    out_rec         = '0;
    out_last        = 1'b1;

    case (state)
      ST_IDLE: begin
        if (req_take) begin
          if (req.opcode == OP_INSERT) begin
            if (count == CW'(ENTRIES)) begin
              res_status_next = STATUS_FULL;
              state_next      = ST_INS_DONE;
            end else if (count == '0) begin
              j_next     = '0;
              state_next = ST_INS_PUT;
            end else begin
              // Start at the top entry and work downwards.
              ram_re     = 1'b1;
              ram_raddr  = AW'(count - CW'(1));
              j_next     = AW'(count);
              state_next = ST_INS_CMP;
            end
          end else begin
            i_next          = '0;
            pend_valid_next = 1'b0;
            state_next      = ST_LK_RD;
          end
        end
      end

      ST_INS_CMP: begin
        // ram_rdata holds entry j-1.
        if (ram_rdata.name_key > new_rec.name_key) begin
          ram_we    = 1'b1;
          ram_waddr = j;
          ram_wdata = ram_rdata;
          j_next    = j - AW'(1);
          if (j == AW'(1)) begin
            state_next = ST_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = j - AW'(2);
          end
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = j;
          ram_wdata       = new_rec;
          count_next      = count + CW'(1);
          res_status_next = STATUS_STORED;
          state_next      = ST_INS_DONE;
        end
      end

      ST_INS_PUT: begin
        ram_we          = 1'b1;
        ram_waddr       = j;
        ram_wdata       = new_rec;
        count_next      = count + CW'(1);
        res_status_next = STATUS_STORED;
        state_next      = ST_INS_DONE;
      end

      ST_INS_DONE: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_status = res_status;
          state_next = ST_IDLE;
        end
      end

      ST_LK_RD: begin
        if (i == count) begin
          state_next = ST_LK_END;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = i[AW-1:0];
          state_next = ST_LK_CMP;
        end
      end

      ST_LK_CMP: begin
        // No read is issued while waiting here, so ram_rdata stays put.
        if (ram_rdata.name_key == new_rec.name_key) begin
          if (!pend_valid) begin
            pend_valid_next = 1'b1;
            pend_rec_next   = ram_rdata;
            i_next          = i + CW'(1);
            state_next      = ST_LK_RD;
          end else if (slot_free) begin
            out_load      = 1'b1;
            out_status    = STATUS_FOUND;
            out_rec       = pend_rec;
            out_last      = 1'b0;
            pend_rec_next = ram_rdata;
            i_next        = i + CW'(1);
            state_next    = ST_LK_RD;
          end
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_LK_RD;
        end
      end

      ST_LK_END: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (pend_valid) begin
            out_status = STATUS_FOUND;
            out_rec    = pend_rec;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status        <= out_status;
      rsp.found_name    <= out_rec.name_key;
      rsp.found_address <= out_rec.address_key;
      rsp.found_phone   <= out_rec.phone;
      rsp.last          <= out_last;
    end
  end

  assign rsp.valid = rsp_valid;
endmodule

FILE: rtl/srt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/srt_checker.sv
// Port-level assertions for the sorted record table, bound to the top level.
module srt_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input srt_pkg::status_t rsp_status,
  input logic [63:0]    rsp_found_name,
  input logic           rsp_last
);
  import srt_pkg::*;

  // A response that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response withdrawn before transfer");

  // Insert results always close their request.
  a_insert_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STATUS_STORED || rsp_status == STATUS_FULL) |-> rsp_last)
    else $error("insert result without last flag");

  // A miss is a single, empty response.
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STATUS_NOT_FOUND |-> rsp_last && rsp_found_name == '0)
    else $error("not-found response malformed");

  // While a lookup still has matches to report, no new request is taken.
  a_no_accept_mid_lookup: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("request accepted while a lookup is still running");

  // Nothing is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");
endmodule

bind sorted_record_table_unit srt_checker u_srt_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_found_name (rsp.found_name),
  .rsp_last       (rsp.last)
);

FILE: bench/sorted_record_table_unit_tb.sv
// Self-checking testbench of the sorted record table: ordered inserts, lookups and a full table.
module sorted_record_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int ENTRIES = 16;
  // Every lookup scans at most 16 entries and sends at most 16 results, each held back
  // by the receiver.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // Cycles allowed after the last expected result, so that anything extra shows up.
  localparam int DRAIN_CYCLES = 60;

  // One expected transfer on the response channel.
  typedef struct {
    status_t     status;
    logic [63:0] name;
    logic [63:0] address;
    logic [30:0] phone;
    logic        last;
  } response_t;

  logic clk;
  logic rst;

  srt_req_if req_ch ();
  srt_rsp_if rsp_ch ();

  sorted_record_table_unit #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Our own copy of the table. It is updated at the edge on which a request transfer
  // takes place, so it always describes the table as the next request will find it.
  logic [63:0] table_names     [ENTRIES];
  logic [63:0] table_addresses [ENTRIES];
  logic [30:0] table_phones    [ENTRIES];
  int          table_count = 0;

  response_t   pending_responses[$];
  int          error_count = 0;
  int          send_idle_pct = 35;
  int          recv_idle_pct = 68;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard: if the expected results never all arrive, the run ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Works out the results of one accepted request and updates the table copy.
  // An insert goes after every entry whose name is less than or equal to its own, so
  // equal names stay in the order in which they arrived.
  task automatic predict_table_response(input opcode_t op, input logic [63:0] name,
                                        input logic [63:0] address, input logic [30:0] phone);
    response_t resp;
    int        pos;
    int        match_count;
    resp = '{STATUS_STORED, 64'd0, 64'd0, 31'd0, 1'b1};
    match_count = 0;
    if (op == OP_INSERT) begin
      if (table_count >= ENTRIES) begin
        resp.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < table_count && table_names[pos] <= name) pos++;
        for (int i = table_count; i > pos; i--) begin
          table_names[i]     = table_names[i - 1];
          table_addresses[i] = table_addresses[i - 1];
          table_phones[i]    = table_phones[i - 1];
        end
        table_names[pos]     = name;
        table_addresses[pos] = address;
        table_phones[pos]    = phone;
        table_count++;
      end
      pending_responses.push_back(resp);
    end else begin
      for (int i = 0; i < table_count; i++) begin
        if (table_names[i] == name) begin
          resp = '{STATUS_FOUND, table_names[i], table_addresses[i], table_phones[i], 1'b0};
          pending_responses.push_back(resp);
          match_count++;
        end
      end
      if (match_count == 0) begin
        resp = '{STATUS_NOT_FOUND, 64'd0, 64'd0, 31'd0, 1'b1};
      end else begin
        // Only the final match of a lookup carries the last flag.
        resp = pending_responses.pop_back();
        resp.last = 1'b1;
      end
      pending_responses.push_back(resp);
    end
  endtask

  // Sends one request. It is entered and left at a rising edge; a gap lowers valid,
  // otherwise valid stays high from one request straight into the next, so valid gets
  // one assignment per edge at most.
  task automatic send_item(input opcode_t op, input logic [63:0] name,
                           input logic [63:0] address, input logic [30:0] phone);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.name_key    <= name;
    req_ch.address_key <= address;
    req_ch.phone       <= phone;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_table_response(op, name, address, phone);
  endtask

  // A name key: mostly a short printable string, zero padded as the block expects,
  // sometimes a fully random 64-bit pattern so that every bit is exercised.
  function automatic logic [63:0] make_name();
    logic [63:0] key;
    int          len;
    key = '0;
    if ($urandom_range(3) == 0) return {$urandom, $urandom};
    len = $urandom_range(8, 1);
    for (int i = 0; i < len; i++) key[63 - 8 * i -: 8] = 8'($urandom_range(8'h7e, 8'h20));
    return key;
  endfunction

  function automatic logic [63:0] pick_stored_name();
    if (table_count == 0) return make_name();
    return table_names[$urandom_range(table_count - 1)];
  endfunction

  // The receiver stalls at random by the current percentage.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every response transfer is compared, field by field, with the oldest expectation.
  initial begin
    response_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("result with nothing expected, status", 64'(rsp_ch.status), 64'd0);
        end else begin
          want = pending_responses.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
          if (rsp_ch.found_name !== want.name)
            report_mismatch("found_name", rsp_ch.found_name, want.name);
          if (rsp_ch.found_address !== want.address)
            report_mismatch("found_address", rsp_ch.found_address, want.address);
          if (rsp_ch.found_phone !== want.phone)
            report_mismatch("found_phone", 64'(rsp_ch.found_phone), 64'(want.phone));
          if (rsp_ch.last !== want.last)
            report_mismatch("last", 64'(rsp_ch.last), 64'(want.last));
        end
      end
    end
  end

  // A lookup in the empty table can only miss, whatever its key.
  task automatic test_lookup_empty_table();
    send_item(OP_LOOKUP, 64'd0, {$urandom, $urandom}, 31'($urandom));
    send_item(OP_LOOKUP, '1, {$urandom, $urandom}, 31'($urandom));
  endtask

  // Extreme keys at both ends of the order, equal names in arrival order, and lookups
  // that hit once, hit twice, or miss on a prefix or an extension of a stored name.
  task automatic test_ordered_inserts();
    send_item(OP_INSERT, '1, 64'd0, 31'h7fffffff);
    send_item(OP_INSERT, 64'd0, '1, 31'd0);
    send_item(OP_INSERT, 64'h626f620000000000, 64'h3120526f61640000, 31'd5550101);
    send_item(OP_INSERT, 64'h616c696365000000, 64'h3220537472656574, 31'd5550202);
    send_item(OP_INSERT, 64'h626f620000000000, 64'h3320506c61636500, 31'd5550303);
    send_item(OP_INSERT, 64'd0, 64'h00000000000000ff, 31'd1);
    send_item(OP_LOOKUP, '1, 64'd0, 31'd0);
    send_item(OP_LOOKUP, 64'd0, '1, 31'h7fffffff);
    send_item(OP_LOOKUP, 64'h626f620000000000, {$urandom, $urandom}, 31'($urandom));
    send_item(OP_LOOKUP, 64'h616c696365000000, {$urandom, $urandom}, 31'($urandom));
    send_item(OP_LOOKUP, 64'h626f622079000000, {$urandom, $urandom}, 31'($urandom));
    send_item(OP_LOOKUP, 64'h626f000000000000, {$urandom, $urandom}, 31'($urandom));
  endtask

  // Mostly lookups of stored names, so that the scan finds runs of matches, with
  // neighbouring and fresh keys for misses. Inserts are rare, as the table never
  // shrinks: over the whole run it fills up and then reports full.
  task automatic test_random_traffic(input int items);
    opcode_t     op;
    logic [63:0] name;
    repeat (items) begin
      if ($urandom_range(99) < 5) begin
        op = OP_INSERT;
        name = ($urandom_range(99) < 55) ? pick_stored_name() : make_name();
      end else begin
        op = OP_LOOKUP;
        case ($urandom_range(9))
          0, 1: name = make_name();
          2: name = pick_stored_name() + 64'd1;
          3: name = pick_stored_name() - 64'd1;
          default: name = pick_stored_name();
        endcase
      end
      send_item(op, name, {$urandom, $urandom}, 31'($urandom));
    end
  endtask

  // Whatever room is left is filled, then further inserts must be refused and the
  // lookups must still see the whole table, first and last entries included.
  task automatic test_table_full();
    while (table_count < ENTRIES)
      send_item(OP_INSERT, make_name(), {$urandom, $urandom}, 31'($urandom));
    send_item(OP_INSERT, 64'd0, '1, 31'h7fffffff);
    send_item(OP_INSERT, make_name(), {$urandom, $urandom}, 31'($urandom));
    send_item(OP_LOOKUP, table_names[0], 64'd0, 31'd0);
    send_item(OP_LOOKUP, table_names[ENTRIES - 1], 64'd0, 31'd0);
  endtask

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= OP_INSERT;
    req_ch.name_key    <= '0;
    req_ch.address_key <= '0;
    req_ch.phone       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The sender idles first less than the receiver, then more, then neither idles.
    send_idle_pct = 35;
    recv_idle_pct = 68;
    test_lookup_empty_table();
    test_ordered_inserts();
    test_random_traffic(125);
    send_idle_pct = 68;
    recv_idle_pct = 35;
    test_random_traffic(125);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(120);
    test_table_full();

    // Wait for every expected result, then a little longer to catch any extra one.
    req_ch.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
